[rtl/core/bitmap_page_allocator_assert.svh]
// Assertion helpers for the page allocator. Compiled out under SYNTHESIS.
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define BPA_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPA_NEVER(name, clk, rst_n, expr, msg) \
	`BPA_ASSERT(name, clk, rst_n, !(expr), msg)
`else
`define BPA_ASSERT(name, clk, rst_n, prop, msg)
`define BPA_NEVER(name, clk, rst_n, expr, msg)
`endif

`endif

[rtl/core/bpa_pkg.sv]
`default_nettype none

package bpa_pkg;

	localparam int unsigned BLOCK_BYTES_DEF  = 4096;
	localparam int unsigned BITMAP_WORDS_DEF = 1024;

	localparam int unsigned WORD_W = 32;
	localparam logic [WORD_W-1:0] ALL_ONES = '1;

	// request codes
	localparam logic [1:0] MODE_MARK_USED  = 2'd0;
	localparam logic [1:0] MODE_MARK_FREE  = 2'd1;
	localparam logic [1:0] MODE_ALLOC      = 2'd2;
	localparam logic [1:0] MODE_FREE_BLOCK = 2'd3;

	// counter operations
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ADD  = 2'd1;
	localparam logic [1:0] CNT_SUB  = 2'd2;

	typedef struct packed {
		logic       clear_wr;
		logic       item_load;
		logic       div_go_base;
		logic       div_go_bytes;
		logic       take_start;
		logic       take_n;
		logic       range_calc;
		logic       region_init;
		logic       region_wr;
		logic       scan_first;
		logic       scan_step;
		logic       alloc_wr;
		logic [1:0] cnt_op;
		logic       cnt_one;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       clear_last;
		logic       skip;
		logic       word_last;
		logic       scan_hit;
		logic       scan_end;
		logic       blk_zero;
	} sts_t;

endpackage

`default_nettype wire

[rtl/core/bpa_div.sv]
`default_nettype none

// Division by the power-of-two block size: a registered right shift.
module bpa_div #(
	parameter int unsigned DIVISOR = 4096,
	parameter int unsigned W       = 33
) (
	input  wire logic         clk,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	output logic [W-1:0]      quotient
);

	localparam int unsigned SH = $clog2(DIVISOR);

	logic [W-1:0] quot_q;

	always_ff @(posedge clk) begin
		if (start)
			quot_q <= dividend >> SH;
	end

	assign quotient = quot_q;

endmodule

`default_nettype wire

[rtl/core/bpa_datapath.sv]
`default_nettype none

`include "bitmap_page_allocator_assert.svh"

module bpa_datapath #(
	parameter int unsigned BLOCK_BYTES  = 4096,
	parameter int unsigned BITMAP_WORDS = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bpa_pkg::cmd_t cmd,
	output bpa_pkg::sts_t      sts,
	input  wire logic [1:0]    mode,
	input  wire logic [31:0]   base_address,
	input  wire logic [31:0]   region_bytes,
	output logic [31:0]        block_address,
	output logic               found,
	output logic [15:0]        used_blocks
);

	import bpa_pkg::*;

	localparam int unsigned WAW       = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int unsigned BKW       = WAW + 5;
	localparam int unsigned TOTAL     = BITMAP_WORDS * 32;
	localparam int unsigned DLW       = $clog2(TOTAL + 1);
	localparam int unsigned COUNT_MAX = (TOTAL > 65535) ? 65535 : TOTAL;
	localparam int unsigned CSW       = ((DLW > 16) ? DLW : 16) + 1;
	localparam int unsigned QW        = 33;
	localparam int unsigned PW        = BKW + 17;
	localparam int unsigned BSH       = $clog2(BLOCK_BYTES);
	localparam logic [QW:0]    TOTAL_E = (QW + 1)'(TOTAL);
	localparam logic [WAW-1:0] LAST_W  = WAW'(BITMAP_WORDS - 1);

	// bitmap storage
	logic [WORD_W-1:0] bitmap_mem [BITMAP_WORDS];
	logic [WORD_W-1:0] rdata_q;
	logic [WAW-1:0]    rd_idx_q;
	logic              re;
	logic [WAW-1:0]    raddr;
	logic              we;
	logic [WAW-1:0]    waddr;
	logic [WORD_W-1:0] wdata;

	// request registers
	logic [1:0]    mode_q;
	logic [31:0]   base_q;
	logic [QW-1:0] dvdb_q;
	logic [QW-1:0] start_q;
	logic [QW-1:0] n_q;
	logic [DLW-1:0] end_q;
	logic          skip_q;

	// region walk
	logic [WAW-1:0] word_q;
	logic [WAW-1:0] first_word_q;
	logic [WAW-1:0] last_word_q;
	logic [4:0]     lo_q;
	logic [4:0]     hi_q;
	logic [DLW-1:0] delta_q;
	logic           set_q;

	// allocation
	logic [BKW-1:0]    blk_q;
	logic [WORD_W-1:0] wd_q;
	logic [31:0]       addr_q;
	logic              found_q;

	logic [15:0] count_q;
	logic [31:0] out_addr_q;
	logic        out_found_q;
	logic [15:0] out_used_q;

	// block number of an address or a rounded-up length
	logic          div_start;
	logic [QW-1:0] div_dvd;
	logic [QW-1:0] div_quot;

	assign div_start = cmd.div_go_base | cmd.div_go_bytes;
	assign div_dvd   = cmd.div_go_base ? {1'b0, base_q} : dvdb_q;

	bpa_div #(
		.DIVISOR (BLOCK_BYTES),
		.W       (QW)
	) u_div (
		.clk      (clk),
		.start    (div_start),
		.dividend (div_dvd),
		.quotient (div_quot)
	);

	// range arithmetic
	logic [QW-1:0]  n_ext;
	logic [QW:0]    sum_e;
	logic [DLW-1:0] start_d;
	logic [DLW-1:0] endm1;

	assign n_ext   = (mode_q == MODE_FREE_BLOCK) ? QW'(1) : n_q;
	assign sum_e   = {1'b0, start_q} + {1'b0, n_ext};
	assign start_d = start_q[DLW-1:0];
	assign endm1   = end_q - DLW'(1);

	// per-word mask for region marking
	logic [4:0]        lo_sel;
	logic [4:0]        hi_sel;
	logic [WORD_W-1:0] mask;
	logic              word_last;

	assign word_last = word_q == last_word_q;
	assign lo_sel    = (word_q == first_word_q) ? lo_q : 5'd0;
	assign hi_sel    = word_last ? hi_q : 5'd31;
	assign mask      = (ALL_ONES << lo_sel) & (ALL_ONES >> (5'd31 - hi_sel));

	// first clear bit of the word under scan
	logic [4:0] bit_idx;
	logic       scan_hit;
	logic       scan_end;

	always_comb begin
		bit_idx = 5'd0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!rdata_q[i])
				bit_idx = 5'(i);
		end
	end

	assign scan_hit = rdata_q != ALL_ONES;
	assign scan_end = rd_idx_q == LAST_W;

	logic [PW-1:0] prod;
	assign prod = PW'(blk_q) << BSH;

	// memory port selection
	always_comb begin
		re    = 1'b0;
		raddr = word_q;
		if (cmd.region_init) begin
			re    = 1'b1;
			raddr = start_d[BKW-1:5];
		end else if (cmd.region_wr && !word_last) begin
			re    = 1'b1;
			raddr = word_q + WAW'(1);
		end else if (cmd.scan_first) begin
			re    = 1'b1;
			raddr = '0;
		end else if (cmd.scan_step && !scan_end) begin
			re    = 1'b1;
			raddr = rd_idx_q + WAW'(1);
		end
	end

	assign we    = cmd.clear_wr | cmd.region_wr | cmd.alloc_wr;
	assign waddr = cmd.alloc_wr ? blk_q[BKW-1:5] : word_q;

	always_comb begin
		if (cmd.clear_wr)
			wdata = ALL_ONES;
		else if (cmd.region_wr)
			wdata = set_q ? (rdata_q | mask) : (rdata_q & ~mask);
		else
			wdata = wd_q;
	end

	always_ff @(posedge clk) begin
		if (we)
			bitmap_mem[waddr] <= wdata;
		if (re) begin
			rdata_q  <= bitmap_mem[raddr];
			rd_idx_q <= raddr;
		end
	end

	// used block counter
	logic [CSW-1:0] addend;
	logic [CSW-1:0] count_e;
	logic [CSW-1:0] cnt_sum;
	logic [CSW-1:0] cnt_diff;

	assign addend   = cmd.cnt_one ? CSW'(1) : CSW'(delta_q);
	assign count_e  = CSW'(count_q);
	assign cnt_sum  = count_e + addend;
	assign cnt_diff = count_e - addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			word_q  <= '0;
		end else begin
			case (cmd.cnt_op)
				CNT_ADD: count_q <= (cnt_sum > CSW'(COUNT_MAX)) ? 16'(COUNT_MAX)
				                                                : cnt_sum[15:0];
				CNT_SUB: count_q <= (addend >= count_e) ? 16'd0 : cnt_diff[15:0];
				default: count_q <= count_q;
			endcase
			if (cmd.clear_wr && !(word_q == LAST_W))
				word_q <= word_q + WAW'(1);
			else if (cmd.region_init)
				word_q <= start_d[BKW-1:5];
			else if (cmd.region_wr && !word_last)
				word_q <= word_q + WAW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			mode_q  <= mode;
			base_q  <= base_address;
			dvdb_q  <= {1'b0, region_bytes} + QW'(BLOCK_BYTES - 1);
			addr_q  <= '0;
			found_q <= 1'b0;
		end
		if (cmd.take_start)
			start_q <= div_quot;
		if (cmd.take_n)
			n_q <= div_quot;
		if (cmd.range_calc) begin
			end_q  <= (sum_e > TOTAL_E) ? DLW'(TOTAL) : sum_e[DLW-1:0];
			skip_q <= ({1'b0, start_q} >= TOTAL_E) || (n_ext == '0);
		end
		if (cmd.region_init) begin
			first_word_q <= start_d[BKW-1:5];
			last_word_q  <= endm1[BKW-1:5];
			lo_q         <= start_d[4:0];
			hi_q         <= endm1[4:0];
			delta_q      <= end_q - start_d;
			set_q        <= mode_q == MODE_MARK_USED;
		end
		if (cmd.scan_step) begin
			blk_q <= {rd_idx_q, bit_idx};
			wd_q  <= rdata_q | (WORD_W'(1) << bit_idx);
		end
		if (cmd.alloc_wr) begin
			addr_q  <= 32'(prod);
			found_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_addr_q  <= addr_q;
			out_found_q <= found_q;
			out_used_q  <= count_q;
		end
	end

	assign sts.mode       = mode_q;
	assign sts.clear_last = word_q == LAST_W;
	assign sts.skip       = skip_q;
	assign sts.word_last  = word_last;
	assign sts.scan_hit   = scan_hit;
	assign sts.scan_end   = scan_end;
	assign sts.blk_zero   = (rd_idx_q == '0) && (bit_idx == 5'd0);

	assign block_address = out_addr_q;
	assign found         = out_found_q;
	assign used_blocks   = out_used_q;

	`BPA_ASSERT(a_count_bound, clk, arst_n, count_q <= 16'(COUNT_MAX), "used count above block total")
	`BPA_ASSERT(a_region_window, clk, arst_n, cmd.region_wr |-> (word_q >= first_word_q && word_q <= last_word_q), "region write outside range")
	`BPA_NEVER(a_alloc_nonzero, clk, arst_n, cmd.alloc_wr && blk_q == '0, "reserved block allocated")
	`BPA_ASSERT(a_block_pow2, clk, arst_n, (BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0, "block size not a power of two")

endmodule

`default_nettype wire

[rtl/core/bpa_ctrl.sv]
`default_nettype none

`include "bitmap_page_allocator_assert.svh"

module bpa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [1:0]    mode,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire bpa_pkg::sts_t sts,
	output bpa_pkg::cmd_t      cmd
);

	import bpa_pkg::*;

	localparam logic [3:0] ST_CLEAR     = 4'd0;
	localparam logic [3:0] ST_IDLE      = 4'd1;
	localparam logic [3:0] ST_DIVA_GO   = 4'd2;
	localparam logic [3:0] ST_DIVA_WAIT = 4'd3;
	localparam logic [3:0] ST_DIVB_GO   = 4'd4;
	localparam logic [3:0] ST_DIVB_WAIT = 4'd5;
	localparam logic [3:0] ST_RANGE     = 4'd6;
	localparam logic [3:0] ST_CHECK     = 4'd7;
	localparam logic [3:0] ST_WR        = 4'd8;
	localparam logic [3:0] ST_SCAN_GO   = 4'd9;
	localparam logic [3:0] ST_SCAN      = 4'd10;
	localparam logic [3:0] ST_HIT       = 4'd11;
	localparam logic [3:0] ST_DONE      = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_n;
	logic       out_valid_q;
	logic       out_blocked;

	assign in_stall    = state_q != ST_IDLE;
	assign out_valid   = out_valid_q;
	assign out_blocked = out_valid_q && out_stall;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last)
					state_n = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_n = (mode == MODE_ALLOC) ? ST_SCAN_GO : ST_DIVA_GO;
				end
			end
			ST_DIVA_GO: begin
				cmd.div_go_base = 1'b1;
				state_n = ST_DIVA_WAIT;
			end
			ST_DIVA_WAIT: begin
				cmd.take_start = 1'b1;
				state_n = (sts.mode == MODE_FREE_BLOCK) ? ST_RANGE : ST_DIVB_GO;
			end
			ST_DIVB_GO: begin
				cmd.div_go_bytes = 1'b1;
				state_n = ST_DIVB_WAIT;
			end
			ST_DIVB_WAIT: begin
				cmd.take_n = 1'b1;
				state_n = ST_RANGE;
			end
			ST_RANGE: begin
				cmd.range_calc = 1'b1;
				state_n = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.skip) begin
					state_n = ST_DONE;
				end else begin
					cmd.region_init = 1'b1;
					state_n = ST_WR;
				end
			end
			ST_WR: begin
				cmd.region_wr = 1'b1;
				if (sts.word_last) begin
					// count moves once, on the last word of the region
					cmd.cnt_op = (sts.mode == MODE_MARK_USED) ? CNT_ADD : CNT_SUB;
					state_n = ST_DONE;
				end
			end
			ST_SCAN_GO: begin
				cmd.scan_first = 1'b1;
				state_n = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit)
					state_n = sts.blk_zero ? ST_DONE : ST_HIT;
				else if (sts.scan_end)
					state_n = ST_DONE;
			end
			ST_HIT: begin
				cmd.alloc_wr = 1'b1;
				cmd.cnt_op   = CNT_ADD;
				cmd.cnt_one  = 1'b1;
				state_n = ST_DONE;
			end
			ST_DONE: begin
				if (!out_blocked) begin
					cmd.out_load = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	`BPA_NEVER(a_no_overwrite, clk, arst_n, cmd.out_load && out_blocked, "result overwritten while stalled")
	`BPA_ASSERT(a_done_to_idle, clk, arst_n, cmd.out_load |=> state_q == ST_IDLE, "no return to idle after result")
	`BPA_ASSERT(a_zero_block, clk, arst_n, (state_q == ST_SCAN && sts.scan_hit && sts.blk_zero) |=> state_q == ST_DONE, "reserved block not rejected")

endmodule

`default_nettype wire

[rtl/core/bitmap_page_allocator.sv]
`default_nettype none

// First-fit bitmap page allocator: one bit per block of BLOCK_BYTES bytes
// (1 = used) over BITMAP_WORDS 32-bit words in a single-read-port memory,
// plus a saturating used-block count. BLOCK_BYTES must be a power of two;
// addresses and lengths become block numbers by a shift. After reset a
// clearing pass marks every block used, one bitmap word per cycle, while
// in_stall is high. One request is in work at a time; a finished result
// waits in the output register while the next request is taken. The bitmap
// is read or written one word per cycle: allocate scans from word 0 up to
// the first word with a clear bit or to the last word, free block updates
// one word (none when the block lies beyond the bitmap), and region marking
// writes each bitmap word the region touches. The next request can be taken
// in the cycle after the result is loaded, and a result still stalled at the
// output holds the following one back.
module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int unsigned BLOCK_BYTES  = BLOCK_BYTES_DEF,
	parameter int unsigned BITMAP_WORDS = BITMAP_WORDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] base_address,
	input  wire logic [31:0] region_bytes,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      block_address,
	output logic             found,
	output logic [15:0]      used_blocks
);

	cmd_t cmd;
	sts_t sts;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bpa_datapath #(
		.BLOCK_BYTES  (BLOCK_BYTES),
		.BITMAP_WORDS (BITMAP_WORDS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (mode),
		.base_address  (base_address),
		.region_bytes  (region_bytes),
		.block_address (block_address),
		.found         (found),
		.used_blocks   (used_blocks)
	);

endmodule

`default_nettype wire
